/* hdl/point_in_region_test_core_macros.svh */
// assertion macros for the region test core
`ifndef POINT_IN_REGION_TEST_CORE_MACROS_SVH
`define POINT_IN_REGION_TEST_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PIRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PIRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/pirt_pkg.sv */
// package for the region test core: widths, region kinds, register indexes, types
package pirt_pkg;

  localparam int COORD_BITS   = 16;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int DBL_BITS     = COORD_BITS + 2;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int SUM_BITS     = SQ_BITS + 2;
  localparam int CFG_BITS     = 3 * COORD_BITS;
  localparam int KIND_BITS    = 3;
  localparam int REG_IDX_BITS = 3;

  localparam logic [KIND_BITS-1:0] KIND_BOX    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_SPHERE = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_CYL_X  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_CYL_Y  = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_CYL_Z  = 3'd4;

  localparam logic [REG_IDX_BITS-1:0] REG_REGION_KIND  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_ANCHOR_X     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_ANCHOR_Y     = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ANCHOR_Z     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_UPPER_CORNER = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_PERIOD_SIZE  = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_RADIUS       = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT       = 3'd7;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [DBL_BITS-1:0]   dbl_t;
  typedef logic [SQ_BITS-1:0]           sq_t;
  typedef logic [SUM_BITS-1:0]          sum_t;

  typedef struct packed {
    logic       gate;
    logic       round;
    logic [2:0] axis_on;
  } flags_t;

endpackage

/* hdl/point_in_region_test_core.sv */
// point in region test: one position per cycle through four register stages
// an accepted item moves through the v1, v2 and v3 stages and then raises out_valid
// throughput: one item per cycle when not stalled; diff, wrap, square and sum stages advance together
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
// reset: synchronous, clears stage valids and all configuration registers to zero
`include "point_in_region_test_core_macros.svh"

module point_in_region_test_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pirt_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [pirt_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pirt_pkg::COORD_BITS-1:0]     pos_x,
  input  logic [pirt_pkg::COORD_BITS-1:0]     pos_y,
  input  logic [pirt_pkg::COORD_BITS-1:0]     pos_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                inside_res
);
  import pirt_pkg::*;

  localparam int CB = COORD_BITS;

  logic [KIND_BITS-1:0] region_kind;
  coord_t               anchor_x;
  coord_t               anchor_y;
  coord_t               anchor_z;
  logic [CFG_BITS-1:0]  upper_corner;
  logic [CFG_BITS-1:0]  period_size;
  coord_t               radius;
  coord_t               height;

  logic adv;

  // stage registers
  logic   v1, v2, v3;
  diff_t  d1 [3];
  diff_t  d2 [3];
  sq_t    sq3 [3];
  sq_t    r2;
  flags_t flags1, flags2, flags3;

  // stage 1 combinational
  coord_t p [3];
  coord_t c [3];
  diff_t  d_next [3];
  dbl_t   ax_dbl;
  dbl_t   h_pos;
  logic   in_box;
  logic   axial_ok;
  logic   is_cyl;
  flags_t flags1_next;

  // stage 2 combinational
  diff_t  w_next [3];
  dbl_t   twice;
  dbl_t   per;
  dbl_t   adj;

  // stage 3 combinational
  diff_t  neg [3];
  coord_t mag [3];

  // output stage
  sum_t   sum;
  logic   res_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      region_kind  <= '0;
      anchor_x     <= '0;
      anchor_y     <= '0;
      anchor_z     <= '0;
      upper_corner <= '0;
      period_size  <= '0;
      radius       <= '0;
      height       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_KIND:  region_kind  <= cfg_data[KIND_BITS-1:0];
        REG_ANCHOR_X:     anchor_x     <= cfg_data[CB-1:0];
        REG_ANCHOR_Y:     anchor_y     <= cfg_data[CB-1:0];
        REG_ANCHOR_Z:     anchor_z     <= cfg_data[CB-1:0];
        REG_UPPER_CORNER: upper_corner <= cfg_data;
        REG_PERIOD_SIZE:  period_size  <= cfg_data;
        REG_RADIUS:       radius       <= cfg_data[CB-1:0];
        REG_HEIGHT:       height       <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: differences, box bounds, axial extent
  always_comb begin
    p[0] = pos_x;
    p[1] = pos_y;
    p[2] = pos_z;
    c[0] = anchor_x;
    c[1] = anchor_y;
    c[2] = anchor_z;
    in_box = 1'b1;
    for (int k = 0; k < 3; k++) begin
      d_next[k] = $signed({1'b0, p[k]}) - $signed({1'b0, c[k]});
      if (p[k] < c[k] || p[k] > upper_corner[k*CB +: CB]) begin
        in_box = 1'b0;
      end
    end
    is_cyl = 1'b1;
    ax_dbl = '0;
    flags1_next.axis_on = 3'b111;
    case (region_kind)
      KIND_CYL_X: begin
        ax_dbl = {d_next[0], 1'b0};
        flags1_next.axis_on = 3'b110;
      end
      KIND_CYL_Y: begin
        ax_dbl = {d_next[1], 1'b0};
        flags1_next.axis_on = 3'b101;
      end
      KIND_CYL_Z: begin
        ax_dbl = {d_next[2], 1'b0};
        flags1_next.axis_on = 3'b011;
      end
      default: is_cyl = 1'b0;
    endcase
    h_pos    = $signed({2'b00, height});
    axial_ok = !is_cyl || (ax_dbl >= -h_pos && ax_dbl <= h_pos);
    flags1_next.round = is_cyl || (region_kind == KIND_SPHERE);
    if (region_kind == KIND_BOX) begin
      flags1_next.gate = in_box;
    end else begin
      flags1_next.gate = flags1_next.round && axial_ok;
    end
  end

  // stage 2: one minimum-image correction per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      twice = {d1[k], 1'b0};
      per   = $signed({2'b00, period_size[k*CB +: CB]});
      if (twice > per) begin
        adj = $signed({d1[k][DIFF_BITS-1], d1[k]}) - per;
      end else if (twice < -per) begin
        adj = $signed({d1[k][DIFF_BITS-1], d1[k]}) + per;
      end else begin
        adj = $signed({d1[k][DIFF_BITS-1], d1[k]});
      end
      w_next[k] = adj[DIFF_BITS-1:0];
    end
  end

  // stage 3: magnitudes for the squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k] = -d2[k];
      mag[k] = d2[k][DIFF_BITS-1] ? neg[k][CB-1:0] : d2[k][CB-1:0];
    end
  end

  // output stage: sum of squares against radius squared for round kinds; every kind also needs the gate
  always_comb begin
    sum = {2'b00, sq3[0]} + {2'b00, sq3[1]} + {2'b00, sq3[2]};
    if (flags3.round) begin
      res_next = flags3.gate && (sum <= {2'b00, r2});
    end else begin
      res_next = flags3.gate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1     <= d_next;
      flags1 <= flags1_next;
      d2     <= w_next;
      flags2 <= flags1;
      for (int k = 0; k < 3; k++) begin
        if (flags2.axis_on[k]) begin
          sq3[k] <= sq_t'(mag[k]) * sq_t'(mag[k]);
        end else begin
          sq3[k] <= '0;
        end
      end
      r2         <= sq_t'(radius) * sq_t'(radius);
      flags3     <= flags2;
      inside_res <= res_next;
    end
  end

  `PIRT_ASSERT_NEXT(a_freeze, out_valid && out_stall, out_valid && $stable({v1, v2, v3}), "pipeline moved under stall")
  `PIRT_ASSERT_NEXT(a_enter, in_valid && !in_stall, v1, "accepted item not in first stage")
  `PIRT_ASSERT_NEXT(a_gate, adv && v3 && !flags3.gate, !inside_res, "failed gate gave inside")

endmodule

/* bench/region_checker.sv */
// checker for the region test core: mirrors its registers, predicts each verdict, compares
`timescale 1ns / 100ps

module region_checker
  import pirt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  coord_t                  pos_x,
  input  coord_t                  pos_y,
  input  coord_t                  pos_z,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    inside_res,
  output int                      failures,
  output int                      pending
);

  logic [KIND_BITS-1:0] kind_r;
  coord_t               anchor_x_r;
  coord_t               anchor_y_r;
  coord_t               anchor_z_r;
  logic [CFG_BITS-1:0]  upper_r;
  logic [CFG_BITS-1:0]  period_r;
  coord_t               radius_r;
  coord_t               height_r;

  bit verdict_q[$];
  bit want;

  function automatic bit in_region(coord_t px, coord_t py, coord_t pz);
    coord_t pos[3];
    coord_t ctr[3];
    longint d;
    longint lim;
    longint sum;
    int     axis;
    bit     hit;
    pos = '{px, py, pz};
    ctr = '{anchor_x_r, anchor_y_r, anchor_z_r};
    hit = 1'b0;
    if (kind_r == KIND_BOX) begin
      hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (pos[k] < ctr[k] || pos[k] > upper_r[COORD_BITS*k +: COORD_BITS]) hit = 1'b0;
      end
    end else if (kind_r <= KIND_CYL_Z) begin
      axis = (kind_r == KIND_SPHERE) ? 3 : int'(kind_r - KIND_CYL_X);
      hit = 1'b1;
      // axial extent, no wrap
      if (axis < 3) begin
        d = 2 * (longint'(pos[axis]) - longint'(ctr[axis]));
        if (d < -longint'(height_r) || d > longint'(height_r)) hit = 1'b0;
      end
      if (hit) begin
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          if (k != axis) begin
            d   = longint'(pos[k]) - longint'(ctr[k]);
            lim = longint'(period_r[COORD_BITS*k +: COORD_BITS]);
            // single minimum-image correction
            if (2 * d > lim) d = d - lim;
            else if (2 * d < -lim) d = d + lim;
            sum = sum + d * d;
          end
        end
        hit = (sum <= longint'(radius_r) * longint'(radius_r));
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kind_r     = '0;
      anchor_x_r = '0;
      anchor_y_r = '0;
      anchor_z_r = '0;
      upper_r    = '0;
      period_r   = '0;
      radius_r   = '0;
      height_r   = '0;
      verdict_q.delete();
      failures   = 0;
    end else begin
      if (in_valid && !in_stall) verdict_q.push_back(in_region(pos_x, pos_y, pos_z));
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("inside_res: result with no item pending, actual %0b", inside_res);
          failures++;
        end else begin
          want = verdict_q.pop_front();
          if (inside_res !== want) begin
            $error("inside_res: expected %0b, actual %0b", want, inside_res);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_REGION_KIND:  kind_r     = cfg_data[KIND_BITS-1:0];
          REG_ANCHOR_X:     anchor_x_r = cfg_data[COORD_BITS-1:0];
          REG_ANCHOR_Y:     anchor_y_r = cfg_data[COORD_BITS-1:0];
          REG_ANCHOR_Z:     anchor_z_r = cfg_data[COORD_BITS-1:0];
          REG_UPPER_CORNER: upper_r    = cfg_data;
          REG_PERIOD_SIZE:  period_r   = cfg_data;
          REG_RADIUS:       radius_r   = cfg_data[COORD_BITS-1:0];
          REG_HEIGHT:       height_r   = cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

/* bench/testbench.sv */
// top of the region test bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import pirt_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [REG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  coord_t                  pos_x;
  coord_t                  pos_y;
  coord_t                  pos_z;
  logic                    out_valid;
  logic                    out_stall;
  logic                    inside_res;
  int                      failures;
  int                      pending;

  bit gaps_on;
  bit stalls_on;
  int stuck_cycles;

  logic [KIND_BITS-1:0] cur_kind;
  coord_t               cur_lo[3];
  coord_t               cur_hi[3];
  coord_t               cur_per[3];
  coord_t               cur_rad;
  coord_t               cur_hgt;

  point_in_region_test_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res)
  );

  region_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_item(coord_t x, coord_t y, coord_t z);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    pos_x    = x;
    pos_y    = y;
    pos_z    = z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // writes every register; unused upper data bits carry noise
  task automatic set_region(logic [KIND_BITS-1:0] kind, coord_t ax, coord_t ay, coord_t az,
                            logic [CFG_BITS-1:0] upper, logic [CFG_BITS-1:0] period,
                            coord_t rad, coord_t hgt);
    logic [CFG_BITS-1:0] noise;
    noise = {16'($urandom), 32'($urandom)};
    drain();
    write_reg(REG_REGION_KIND,  {noise[CFG_BITS-1:KIND_BITS], kind});
    write_reg(REG_ANCHOR_X,     {noise[CFG_BITS-1:COORD_BITS], ax});
    write_reg(REG_ANCHOR_Y,     {noise[CFG_BITS-1:COORD_BITS], ay});
    write_reg(REG_ANCHOR_Z,     {noise[CFG_BITS-1:COORD_BITS], az});
    write_reg(REG_UPPER_CORNER, upper);
    write_reg(REG_PERIOD_SIZE,  period);
    write_reg(REG_RADIUS,       {noise[CFG_BITS-1:COORD_BITS], rad});
    write_reg(REG_HEIGHT,       {noise[CFG_BITS-1:COORD_BITS], hgt});
    cur_kind = kind;
    cur_lo   = '{ax, ay, az};
    cur_rad  = rad;
    cur_hgt  = hgt;
    for (int k = 0; k < 3; k++) begin
      cur_hi[k]  = upper[COORD_BITS*k +: COORD_BITS];
      cur_per[k] = period[COORD_BITS*k +: COORD_BITS];
    end
  endtask

  function automatic coord_t jitter(int c, int spread);
    return coord_t'(c + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic coord_t lane_pick(int k);
    int lo;
    int hi;
    int spread;
    lo = int'(cur_lo[k]);
    hi = int'(cur_hi[k]);
    if (cur_kind == KIND_BOX) begin
      if (hi >= lo) return jitter((lo + hi) / 2, (hi - lo) / 2 + 8);
      return jitter(lo, 64);
    end
    spread = int'(cur_rad) + int'(cur_hgt) / 2 + 16;
    // sometimes aim at a periodic image of the center
    if ($urandom_range(0, 3) == 0) return jitter(lo + int'(cur_per[k]), spread);
    return jitter(lo, spread);
  endfunction

  function automatic coord_t random_lane_size();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return coord_t'($urandom_range(0, 65535));
      default: return coord_t'($urandom_range(0, 65535) >> $urandom_range(0, 10));
    endcase
  endfunction

  initial begin
    logic [KIND_BITS-1:0] kind;
    coord_t               ax;
    coord_t               ay;
    coord_t               az;
    logic [CFG_BITS-1:0]  upper;
    logic [CFG_BITS-1:0]  period;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pos_x        = '0;
    pos_y        = '0;
    pos_z        = '0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    stuck_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset registers: box degenerate at the origin
    send_item(16'h0000, 16'h0000, 16'h0000);
    send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);

    // box bounds, inclusive on both sides
    set_region(KIND_BOX, 16'h0100, 16'h0200, 16'h0300, {16'h3000, 16'h2000, 16'h1000},
               {16'h0800, 16'h0800, 16'h0800}, 16'h0000, 16'h0000);
    send_item(16'h0100, 16'h0200, 16'h0300);
    send_item(16'h1000, 16'h2000, 16'h3000);
    send_item(16'h00FF, 16'h0200, 16'h0300);
    send_item(16'h1001, 16'h2000, 16'h3000);
    send_item(16'h0100, 16'h2001, 16'h0300);
    send_item(16'h0100, 16'h0200, 16'h02FF);

    // low corner above high corner gives an empty box
    set_region(KIND_BOX, 16'h2000, 16'h0000, 16'h0000, {16'hFFFF, 16'hFFFF, 16'h1000},
               '0, 16'hFFFF, 16'hFFFF);
    send_item(16'h1800, 16'h0100, 16'h0100);

    // box covering everything
    set_region(KIND_BOX, 16'h0000, 16'h0000, 16'h0000, '1, '1, 16'hFFFF, 16'hFFFF);
    send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);

    // sphere without wrap, on and just past the surface
    set_region(KIND_SPHERE, 16'h2000, 16'h2000, 16'h2000, '0, '0, 16'h0400, 16'h0000);
    send_item(16'h2400, 16'h2000, 16'h2000);
    send_item(16'h2401, 16'h2000, 16'h2000);
    send_item(16'h2000, 16'h1C00, 16'h2000);

    // sphere wrapped across the periodic cell, both directions
    set_region(KIND_SPHERE, 16'h0100, 16'h3F00, 16'h0000, '0,
               {16'h4000, 16'h4000, 16'h4000}, 16'h0400, 16'h0000);
    send_item(16'h3F00, 16'h0100, 16'h0000);
    send_item(16'h2000, 16'h3F00, 16'h2000);
    send_item(16'h2001, 16'h3F00, 16'h0000);

    // cylinders along each axis, axial and radial edges
    for (int a = 0; a < 3; a++) begin
      set_region(KIND_BITS'(KIND_CYL_X + a), 16'h1000, 16'h1000, 16'h1000, '0, '0,
                 16'h0200, 16'h0800);
      send_item((a == 0) ? 16'h1400 : 16'h1200, (a == 1) ? 16'h1400 : 16'h1000,
                (a == 2) ? 16'h1400 : 16'h1000);
      send_item((a == 0) ? 16'h1401 : 16'h1000, (a == 1) ? 16'h0BFF : 16'h1000,
                (a == 2) ? 16'h0C00 : 16'h1000);
    end

    // kinds with no region
    for (int u = 5; u < 8; u++) begin
      set_region(KIND_BITS'(u), 16'h8000, 16'h8000, 16'h8000, '1, '1, 16'hFFFF, 16'hFFFF);
      send_item(16'h8000, 16'h8000, 16'h8000);
    end

    // largest sphere and period
    set_region(KIND_SPHERE, 16'h0000, 16'h0000, 16'h0000, '0, '1, 16'hFFFF, 16'hFFFF);
    send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        kind   = KIND_SPHERE;
        ax     = 16'hFFFF;
        ay     = 16'h0000;
        az     = 16'h8000;
        upper  = '1;
        period = '1;
      end else begin
        kind = ($urandom_range(0, 9) == 0) ? KIND_BITS'($urandom_range(5, 7))
                                           : KIND_BITS'($urandom_range(0, 4));
        ax   = coord_t'($urandom_range(0, 65535));
        ay   = coord_t'($urandom_range(0, 65535));
        az   = coord_t'($urandom_range(0, 65535));
        upper = {az + random_lane_size(), ay + random_lane_size(), ax + random_lane_size()};
        period = {random_lane_size(), random_lane_size(), random_lane_size()};
      end
      set_region(kind, ax, ay, az, upper, period,
                 (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000
                           : coord_t'($urandom_range(0, 65535) >> $urandom_range(0, 10)),
                 (ph == 1) ? 16'h0000
                           : coord_t'($urandom_range(0, 65535) >> $urandom_range(0, 10)));
      gaps_on   = (ph % 4 != 3) && (ph < 11);
      stalls_on = (ph % 4 != 2) && (ph < 11);
      for (int n = 0; n < 100; n++) begin
        // pause the sender until the pipeline has emptied
        if (ph == 5 && n == 50) begin
          in_valid = 1'b0;
          while (pending != 0) @(negedge clk);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_item(coord_t'($urandom_range(0, 65535)), coord_t'($urandom_range(0, 65535)),
                    coord_t'($urandom_range(0, 65535)));
        end else begin
          send_item(lane_pick(0), lane_pick(1), lane_pick(2));
        end
      end
    end

    drain();
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* point_in_region_test_core.f */
+incdir+hdl
hdl/pirt_pkg.sv
hdl/point_in_region_test_core.sv
bench/region_checker.sv
bench/testbench.sv
